### rtl/sass_pkg.sv
package sass_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int CELL_IDX_W  = $clog2(MAX_PATTERN);
  localparam int UNIT_W      = 16;
  localparam int UNITS_PER_REG = 4;
  localparam int PATTERN_REGS  = MAX_PATTERN / UNITS_PER_REG;
  localparam int CFG_DATA_W  = UNIT_W * UNITS_PER_REG;
  localparam int CFG_IDX_W   = 3;
  localparam int LEN_W       = 5;
  localparam int START_W     = 17;
  localparam int OUT_DATA_W  = 40;

  localparam logic [UNIT_W-1:0] ZWSP     = 16'h200B;
  localparam logic [UNIT_W-1:0] UPPER_A  = 16'h0041;
  localparam logic [UNIT_W-1:0] UPPER_Z  = 16'h005A;
  localparam logic [UNIT_W-1:0] CASE_GAP = 16'h0020;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_POSITION  = 3'd6;

  // partial match handed from one cell to the next
  typedef struct packed {
    logic              active;
    logic [UNIT_W-1:0] start;
  } cell_link_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
    logic [UNIT_W-1:0]  match_length;
  } result_t;

  function automatic logic [UNIT_W-1:0] fold(input logic [UNIT_W-1:0] c,
                                             input logic ic);
    logic [UNIT_W-1:0] r;
    r = c;
    if (ic && c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_GAP;
    end
    return r;
  endfunction

endpackage

### rtl/skip_aware_substring_search_unit.sv
// Streaming substring search over UCS-2 text, one 16-bit code unit per word.
// Input stream: s_tdata carries the code unit, s_tlast marks the last unit of
// a segment. Output stream: m_tuser is the found flag, m_tdata carries the
// match start (base position plus index) and the span length, zero skipped
// zero-width spaces included. One result per segment: found on the unit that
// completes the first match, or not-found on the last unit.
// Configuration: cfg_we / cfg_index / cfg_data write the pattern (four units
// per 64-bit register), the pattern length, the case-fold enable and the base
// position. Write only while the block is idle.
// Throughput: one unit per cycle while the output queue has room. The pattern
// is matched by a row of 16 cells, one per pattern unit, each shifting its
// partial match to the next. Each result is queued as its unit is accepted.
// A two-word output queue decouples the sides: s_tready stays high while one
// result waits and drops only when two results are queued.
// Reset (synchronous, rst high) clears the cells, the unit counter, the
// queue and the registers to their defaults (length 1, no folding, base 0).
module skip_aware_substring_search_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [sass_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sass_pkg::CFG_DATA_W-1:0]    cfg_data,
  // text input
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,   // [15:0] code_unit
  input  logic                               s_tlast,   // last_unit
  // results
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sass_pkg::OUT_DATA_W-1:0]    m_tdata,   // [16:0] match_start,
                                                        // [32:17] match_length,
                                                        // [39:33] zero
  output logic                               m_tuser    // found
);

  localparam int NP = sass_pkg::MAX_PATTERN;

  // configuration registers
  logic [sass_pkg::CFG_DATA_W-1:0] pattern_regs [sass_pkg::PATTERN_REGS];
  logic [sass_pkg::LEN_W-1:0]      pattern_length;
  logic                            ignore_case;
  logic [sass_pkg::UNIT_W-1:0]     base_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sass_pkg::PATTERN_REGS; i++) begin
        pattern_regs[i] <= '0;
      end
      pattern_length <= sass_pkg::LEN_W'(1);
      ignore_case    <= 1'b0;
      base_position  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sass_pkg::REG_PATTERN_0:      pattern_regs[0] <= cfg_data;
        sass_pkg::REG_PATTERN_1:      pattern_regs[1] <= cfg_data;
        sass_pkg::REG_PATTERN_2:      pattern_regs[2] <= cfg_data;
        sass_pkg::REG_PATTERN_3:      pattern_regs[3] <= cfg_data;
        sass_pkg::REG_PATTERN_LENGTH: pattern_length  <= cfg_data[sass_pkg::LEN_W-1:0];
        sass_pkg::REG_IGNORE_CASE:    ignore_case     <= cfg_data[0];
        sass_pkg::REG_BASE_POSITION:  base_position   <= cfg_data[sass_pkg::UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // length in use, minus one: 0 reads as 1, anything past the row as full
  logic [sass_pkg::CELL_IDX_W-1:0] tail;
  always_comb begin
    priority if (pattern_length == '0) begin
      tail = '0;
    end else if (pattern_length > sass_pkg::LEN_W'(NP)) begin
      tail = sass_pkg::CELL_IDX_W'(NP - 1);
    end else begin
      tail = sass_pkg::CELL_IDX_W'(pattern_length - sass_pkg::LEN_W'(1));
    end
  end

  // segment state
  logic [sass_pkg::UNIT_W-1:0] unit_index;
  logic                        match_reported;

  logic                        accept;
  logic                        step;
  logic                        clear;
  logic                        hit_any;
  logic [sass_pkg::UNIT_W-1:0] char_folded;

  assign accept      = s_tvalid && s_tready;
  // zero-width spaces and units after a reported match leave the cells alone
  assign step        = accept && !match_reported && (s_tdata != sass_pkg::ZWSP);
  assign char_folded = sass_pkg::fold(s_tdata, ignore_case);

  // cell row: cell 0 starts a fresh candidate at every unit that steps the row
  sass_pkg::cell_link_t in_link  [NP];
  sass_pkg::cell_link_t out_link [NP];
  logic [NP-1:0]        hit_vec;

  assign in_link[0].active = 1'b1;
  assign in_link[0].start  = unit_index;

  for (genvar j = 0; j < NP; j++) begin : g_cell
    if (j > 0) begin : g_link
      assign in_link[j] = out_link[j-1];
    end
    sass_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .clear        (clear),
      .step         (step),
      .in_use       (sass_pkg::CELL_IDX_W'(j) <= tail),
      .ignore_case  (ignore_case),
      .char_folded  (char_folded),
      .pattern_unit (pattern_regs[j / sass_pkg::UNITS_PER_REG]
                       [(j % sass_pkg::UNITS_PER_REG) * sass_pkg::UNIT_W +: sass_pkg::UNIT_W]),
      .in_link      (in_link[j]),
      .out_link     (out_link[j]),
      .hit          (hit_vec[j])
    );
  end

  // full match when the last cell in use lights up
  logic [sass_pkg::UNIT_W-1:0] hit_start;
  assign hit_any   = step && hit_vec[tail];
  assign hit_start = in_link[tail].start;
  assign clear     = accept && (hit_any || s_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_index     <= '0;
      match_reported <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        unit_index     <= '0;
        match_reported <= 1'b0;
      end else begin
        unit_index <= unit_index + sass_pkg::UNIT_W'(1);
        if (hit_any) begin
          match_reported <= 1'b1;
        end
      end
    end
  end

  // result word
  sass_pkg::result_t result;
  logic              push;

  assign push = accept && (hit_any || (s_tlast && !match_reported));

  always_comb begin
    result = '0;
    if (hit_any) begin
      result.found        = 1'b1;
      result.match_start  = {1'b0, base_position} + {1'b0, hit_start};
      result.match_length = unit_index - hit_start + sass_pkg::UNIT_W'(1);
    end
  end

  sass_pkg::result_t head;
  logic              has_room;

  sass_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .has_room  (has_room),
    .valid     (m_tvalid),
    .pop       (m_tvalid && m_tready),
    .head      (head)
  );

  assign s_tready = has_room;
  assign m_tuser  = head.found;
  assign m_tdata  = {{(sass_pkg::OUT_DATA_W - sass_pkg::START_W - sass_pkg::UNIT_W){1'b0}},
                     head.match_length, head.match_start};

endmodule

### rtl/sass_cell.sv
module sass_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clear,
  input  logic                            step,
  input  logic                            in_use,
  input  logic                            ignore_case,
  input  logic [sass_pkg::UNIT_W-1:0]     char_folded,
  input  logic [sass_pkg::UNIT_W-1:0]     pattern_unit,
  input  sass_pkg::cell_link_t            in_link,
  output sass_pkg::cell_link_t            out_link,
  output logic                            hit
);

  logic                        active;
  logic [sass_pkg::UNIT_W-1:0] start;

  // partial match extends through this cell on the current unit
  assign hit = in_use && in_link.active &&
               (sass_pkg::fold(pattern_unit, ignore_case) == char_folded);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      active <= 1'b0;
    end else if (step) begin
      active <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      start <= in_link.start;
    end
  end

  assign out_link.active = active;
  assign out_link.start  = start;

endmodule

### rtl/sass_out_buf.sv
module sass_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sass_pkg::result_t    push_data,
  output logic                 has_room,
  output logic                 valid,
  input  logic                 pop,
  output sass_pkg::result_t    head
);

  sass_pkg::result_t entry [2];
  logic [1:0]        count;
  logic              wr_ptr;
  logic              rd_ptr;

  assign has_room = (count != 2'd2);
  assign valid    = (count != 2'd0);
  assign head     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/sass_checker.sv
module sass_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [sass_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic                               m_tuser
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // input backpressure only when results are queued
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output queue");

  // not-found word carries zero start and length
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("not-found word with nonzero payload");

  // reset leaves the queue empty and the input open
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid && s_tready)
    else $error("queue not empty after reset");

endmodule

bind skip_aware_substring_search_unit sass_checker u_sass_checker (.*);

### verif/skip_aware_substring_search_unit_test.sv
`timescale 1ns / 100ps

module skip_aware_substring_search_unit_test;
  import sass_pkg::*;

  localparam int RANDOM_SETTINGS   = 12;     // register settings in the random part
  localparam int UNITS_PER_SETTING = 105;    // live text units per setting
  localparam int DRAIN_LIMIT       = 5000;   // cycles to wait for outstanding results

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [UNIT_W-1:0]     s_tdata;    // [15:0] code_unit
  logic                  s_tlast;    // last_unit
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;    // [16:0] match_start, [32:17] match_length
  logic                  m_tuser;    // found

  skip_aware_substring_search_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Search mirror: register copies plus the cell chain, advanced per accepted word
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] pattern_reg [PATTERN_REGS];
  logic [LEN_W-1:0]      length_reg;
  logic                  fold_on;
  logic [UNIT_W-1:0]     base_reg;

  logic                  cell_live   [MAX_PATTERN];
  logic [UNIT_W-1:0]     cell_origin [MAX_PATTERN];  // start index carried by each cell
  logic [UNIT_W-1:0]     text_pos;                   // index of the next unit in the segment
  logic                  seg_matched;                // first match of the segment already out

  result_t               pending_results [$];        // oldest expected result at the front

  int mismatches  = 0;
  int found_seen  = 0;
  int miss_seen   = 0;
  int units_sent  = 0;
  int units_live  = 0;   // units sent while the segment had no match out yet
  bit src_idling  = 1'b0;
  bit sink_idling = 1'b0;
  int stall_request = 0; // long receiver hold-off, picked up by the sink process

  // ASCII A-Z to a-z when folding is on, everything else untouched
  function automatic logic [UNIT_W-1:0] fold_letter(input logic [UNIT_W-1:0] c);
    if (fold_on && c >= UPPER_A && c <= UPPER_Z) return c + CASE_GAP;
    return c;
  endfunction

  function automatic logic [UNIT_W-1:0] pattern_at(input int j);
    return pattern_reg[j / UNITS_PER_REG][(j % UNITS_PER_REG) * UNIT_W +: UNIT_W];
  endfunction

  // length register clamped to 1..MAX_PATTERN
  function automatic int used_units();
    int n;
    n = int'(length_reg);
    if (n < 1) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  function automatic void advance_search(input logic [UNIT_W-1:0] cu, input logic lst);
    int                len;
    logic [UNIT_W-1:0] key;
    result_t           r;
    // zero-width space: no cell moves, but text_pos still advances below
    if (!seg_matched && cu != ZWSP) begin
      len = used_units();
      key = fold_letter(cu);
      for (int j = len - 1; j >= 1; j--) begin
        cell_live[j]   = cell_live[j-1] && (fold_letter(pattern_at(j)) == key);
        cell_origin[j] = cell_origin[j-1];
      end
      cell_live[0]   = (fold_letter(pattern_at(0)) == key);
      cell_origin[0] = text_pos;
      for (int j = len; j < MAX_PATTERN; j++) cell_live[j] = 1'b0;
      if (cell_live[len-1]) begin
        r.found        = 1'b1;
        r.match_start  = {1'b0, base_reg} + {1'b0, cell_origin[len-1]};
        r.match_length = text_pos - cell_origin[len-1] + 1'b1;  // wraps with the index
        pending_results.push_back(r);
        seg_matched = 1'b1;
        foreach (cell_live[j]) cell_live[j] = 1'b0;
      end
    end
    if (lst) begin
      // not-found only when the segment never produced a match
      if (!seg_matched) begin
        r = '0;
        pending_results.push_back(r);
      end
      foreach (cell_live[j]) cell_live[j] = 1'b0;
      text_pos    = '0;
      seg_matched = 1'b0;
    end else begin
      text_pos = text_pos + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [UNIT_W-1:0] swap_case(input logic [UNIT_W-1:0] c);
    if (c >= 16'h0041 && c <= 16'h005A) return c + 16'h0020;
    if (c >= 16'h0061 && c <= 16'h007A) return c - 16'h0020;
    return c;
  endfunction

  // small letter set, either case, so partial matches overlap a lot
  function automatic logic [UNIT_W-1:0] pick_letter();
    logic [UNIT_W-1:0] c;
    c = ($urandom_range(0, 1) != 0) ? 16'h0041 : 16'h0061;
    return c + UNIT_W'($urandom_range(0, 5));
  endfunction

  function automatic logic [UNIT_W-1:0] pick_pattern_unit(input bit allow_zwsp);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return pick_letter();
    if (r < 80) return UNIT_W'($urandom_range(16'h0020, 16'h007E));
    if (r < 92) return UNIT_W'($urandom_range(0, 65535));
    if (r < 96) return allow_zwsp ? ZWSP : pick_letter();
    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic logic [UNIT_W-1:0] pick_text_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return pattern_at($urandom_range(0, used_units() - 1));
    if (r < 60) return pick_letter();
    if (r < 70) return ZWSP;
    if (r < 80) begin
      // just around the fold range: '@' 'A' 'Z' '[' '`' 'z' '{'
      case ($urandom_range(0, 6))
        0: return 16'h0040;
        1: return 16'h0041;
        2: return 16'h005A;
        3: return 16'h005B;
        4: return 16'h0060;
        5: return 16'h007A;
        default: return 16'h007B;
      endcase
    end
    return UNIT_W'($urandom_range(0, 65535));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One text word; valid stays up into the next word when there is no gap.
  task automatic send_unit(input logic [UNIT_W-1:0] cu, input logic lst);
    int gap;
    bit live;
    gap = src_idling ? draw_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cu;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    live = !seg_matched;
    advance_search(cu, lst);
    units_sent++;
    if (live) units_live++;
  endtask

  // Registers change only here, with the input idle and nothing outstanding.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
        pattern_reg[idx[1:0]] = val;
      REG_PATTERN_LENGTH: length_reg = val[LEN_W-1:0];
      REG_IGNORE_CASE:    fold_on    = val[0];
      REG_BASE_POSITION:  base_reg   = val[UNIT_W-1:0];
      default: ;
    endcase
  endtask

  // Stop sending, wait for every expected result, then a few cycles of slack.
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_results.size() > 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
      pending_results.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  // One segment: filler, then a clean match, a broken prefix or plain noise,
  // then more filler. The final word carries tlast.
  task automatic send_segment();
    logic [UNIT_W-1:0] seg [$];
    logic [UNIT_W-1:0] u;
    int                len;
    int                kind;
    int                cut;
    len  = used_units();
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 5)) seg.push_back(pick_text_unit());
    if (kind < 60) begin
      // full pattern, case shuffled, zero-width spaces dropped between units
      for (int j = 0; j < len; j++) begin
        if (j > 0 && $urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 2)) seg.push_back(ZWSP);
        u = pattern_at(j);
        if ($urandom_range(0, 99) < (fold_on ? 50 : 8)) u = swap_case(u);
        seg.push_back(u);
      end
    end else if (kind < 80) begin
      // prefix whose final unit has one bit flipped
      cut = $urandom_range(0, len - 1);
      for (int j = 0; j < cut; j++) seg.push_back(pattern_at(j));
      u = pattern_at(cut) ^ (16'h0001 << $urandom_range(0, 15));
      seg.push_back(u);
    end else begin
      repeat ($urandom_range(1, 12)) seg.push_back(UNIT_W'($urandom_range(0, 65535)));
    end
    // trailing filler, sometimes none so the match completes on the last word
    repeat ($urandom_range(0, 3)) seg.push_back(pick_text_unit());
    foreach (seg[i]) send_unit(seg[i], i == seg.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    int pause;
    hold     = 0;
    pause    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        hold          = stall_request;
        stall_request = 0;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (pause > 0) begin
        m_tready <= 1'b0;
        pause--;
      end else begin
        m_tready <= 1'b1;
        if (sink_idling) pause = draw_gap();
      end
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: found=%0d start=%0d length=%0d",
               m_tuser, m_tdata[START_W-1:0], m_tdata[START_W +: UNIT_W]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_tuser);
          mismatches++;
        end
        if (m_tdata[START_W-1:0] !== want.match_start) begin
          $error("match_start: expected %0d, got %0d",
                 want.match_start, m_tdata[START_W-1:0]);
          mismatches++;
        end
        if (m_tdata[START_W +: UNIT_W] !== want.match_length) begin
          $error("match_length: expected %0d, got %0d",
                 want.match_length, m_tdata[START_W +: UNIT_W]);
          mismatches++;
        end
        if (want.found) found_seen++;
        else miss_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Registers at reset: length 1, unit 0x0000, exact compare, base 0.
  task automatic test_reset_defaults();
    send_unit(16'h0000, 1'b0);   // found at 0, length 1
    send_unit(16'hFFFF, 1'b1);   // after the match: last word gives nothing
    drain();
  endtask

  // Folded "AbC", base at the top so the start needs bit 16.
  task automatic test_case_fold_and_skip();
    write_reg(REG_PATTERN_0, {16'd0, 16'h0043, 16'h0062, 16'h0041});
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(3));
    write_reg(REG_IGNORE_CASE, CFG_DATA_W'(1));
    write_reg(REG_BASE_POSITION, CFG_DATA_W'(16'hFFFF));
    // zero-width space inside the match counts in the span, trailing one does not
    send_unit(16'h0078, 1'b0);   // x
    send_unit(16'h0061, 1'b0);   // a
    send_unit(ZWSP,     1'b0);
    send_unit(16'h0042, 1'b0);   // B
    send_unit(16'h0063, 1'b0);   // c -> start 0x10000, length 4
    send_unit(ZWSP,     1'b1);
    // leading zero-width space never starts a match; match lands on the last word
    send_unit(ZWSP,     1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0043, 1'b1);
    // near miss, not-found on the last word
    send_unit(16'h0061, 1'b0);
    send_unit(16'h0062, 1'b0);
    send_unit(16'h0071, 1'b1);
    drain();
  endtask

  // A pattern unit equal to the zero-width space can never match.
  task automatic test_unmatchable_pattern_unit();
    write_reg(REG_PATTERN_0, {32'd0, ZWSP, 16'h0061});
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(2));
    send_unit(16'h0061, 1'b0);
    send_unit(ZWSP,     1'b0);
    send_unit(16'h0061, 1'b1);
    drain();
  endtask

  // Length 0 behaves as 1, anything above the cell count as the full row.
  task automatic test_length_clamp();
    write_reg(REG_PATTERN_0, 64'h0061);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(0));
    write_reg(REG_BASE_POSITION, CFG_DATA_W'(0));
    send_unit(16'h0061, 1'b1);
    drain();
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(31));
    send_unit(16'h0061, 1'b1);
    drain();
  endtask

  task automatic test_random_segments();
    logic [UNIT_W-1:0]     units [MAX_PATTERN];
    logic [CFG_DATA_W-1:0] regs  [PATTERN_REGS];
    int                    len;
    int                    mark;
    for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
      // first settings hold the extremes; zero-width spaces in the pattern later on
      for (int j = 0; j < MAX_PATTERN; j++) units[j] = pick_pattern_unit(ph >= 4);
      if (ph == 0) begin
        for (int j = 0; j < 4; j++) units[j] = 16'h0000;
        for (int j = 12; j < MAX_PATTERN; j++) units[j] = 16'hFFFF;
      end
      for (int k = 0; k < PATTERN_REGS; k++)
        regs[k] = {units[4*k+3], units[4*k+2], units[4*k+1], units[4*k]};
      case (ph)
        0: len = 16;
        1: len = 31;
        2: len = 1;
        3: len = 0;
        default: begin
          if ($urandom_range(0, 99) < 60) len = $urandom_range(1, 5);
          else if ($urandom_range(0, 99) < 80) len = $urandom_range(6, 16);
          else len = $urandom_range(17, 31);
        end
      endcase
      write_reg(REG_PATTERN_0, regs[0]);
      write_reg(REG_PATTERN_1, regs[1]);
      write_reg(REG_PATTERN_2, regs[2]);
      write_reg(REG_PATTERN_3, regs[3]);
      write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
      write_reg(REG_IGNORE_CASE,
                CFG_DATA_W'((ph == 0) ? 1 : (ph == 1) ? 0 : $urandom_range(0, 1)));
      write_reg(REG_BASE_POSITION,
                CFG_DATA_W'((ph == 0) ? 16'hFFFF : (ph == 2) ? 16'h0000 :
                            UNIT_W'($urandom_range(0, 65535))));
      // idling mostly on, some settings run back to back
      src_idling  = ($urandom_range(0, 3) != 0);
      sink_idling = ($urandom_range(0, 3) != 0);
      mark = units_live;
      while (units_live - mark < UNITS_PER_SETTING) send_segment();
      drain();
    end
  endtask

  // One-word segments all produce results; the receiver holds off long enough
  // for the output queue to fill and the input to stall.
  task automatic test_backpressure();
    write_reg(REG_PATTERN_0, 64'h0061);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(1));
    write_reg(REG_IGNORE_CASE, CFG_DATA_W'(0));
    write_reg(REG_BASE_POSITION, CFG_DATA_W'(16'h1234));
    src_idling    = 1'b0;
    sink_idling   = 1'b0;
    stall_request = 400;
    repeat (60) send_unit(pick_letter(), 1'b1);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    foreach (pattern_reg[k]) pattern_reg[k] = '0;
    length_reg = LEN_W'(1);
    fold_on    = 1'b0;
    base_reg   = '0;
    foreach (cell_live[j]) begin
      cell_live[j]   = 1'b0;
      cell_origin[j] = '0;
    end
    text_pos    = '0;
    seg_matched = 1'b0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    src_idling  = 1'b1;
    sink_idling = 1'b1;
    test_reset_defaults();
    test_case_fold_and_skip();
    test_unmatchable_pattern_unit();
    test_length_clamp();
    test_random_segments();
    test_backpressure();

    $display("Sent %0d text words (%0d reached the cells) over %0d random settings,",
             units_sent, units_live, RANDOM_SETTINGS);
    $display("plus a long output stall: %0d matches, %0d misses checked.",
             found_seen, miss_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // safety net, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
